/* src/risp_pkg.sv */
// Shared types, constants and helper functions for the radix integer string parser.
package risp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int CH_W            = 8;
    localparam int RADIX_W         = 6;
    localparam int WIDX_W          = 4;

    // Parse phase within one string
    typedef enum logic [1:0] {
        PH_START,
        PH_AFTER_SIGN,
        PH_AFTER_ZERO,
        PH_DIGITS
    } t_phase;

    // Result classification
    typedef enum logic [1:0] {
        ST_NUMBER = 2'd0,
        ST_NAN    = 2'd1,
        ST_INF    = 2'd2
    } t_status;

    // One input word as held in the input register
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [RADIX_W-1:0] radix;
        logic               last;
        logic               empty_req;
    } t_item;

    // Control part of one result word
    typedef struct packed {
        t_status status;
        logic    negative;
        logic    overflow;
    } t_flags;

    // Decoded digit
    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } t_digit;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = "+";
    localparam logic [CH_W-1:0] CH_MINUS = "-";
    localparam logic [CH_W-1:0] CH_0     = "0";
    localparam logic [CH_W-1:0] CH_9     = "9";
    localparam logic [CH_W-1:0] CH_LA    = "a";
    localparam logic [CH_W-1:0] CH_LZ    = "z";
    localparam logic [CH_W-1:0] CH_UA    = "A";
    localparam logic [CH_W-1:0] CH_UZ    = "Z";
    localparam logic [CH_W-1:0] CH_LX    = "x";
    localparam logic [CH_W-1:0] CH_UX    = "X";

    localparam logic [RADIX_W-1:0] RADIX_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_XLIMIT = 6'd34;
    localparam logic [RADIX_W-1:0] ALPHA_BASE   = 6'd10;

    // Word match: index 8 waits for a terminator, index 9 is locked equal
    localparam logic [WIDX_W-1:0] WIDX_TERM = 4'd8;
    localparam logic [WIDX_W-1:0] WIDX_LOCK = 4'd9;

    function automatic t_digit digit_of(input logic [CH_W-1:0] c);
        t_digit r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r.val = RADIX_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r.val = RADIX_W'(c - CH_LA) + ALPHA_BASE;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            r.val = RADIX_W'(c - CH_UA) + ALPHA_BASE;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Characters of "Infinity"
    function automatic logic [CH_W-1:0] inf_char(input logic [2:0] idx);
        logic [CH_W-1:0] r;
        unique case (idx)
            3'd0:    r = "I";
            3'd1:    r = "n";
            3'd2:    r = "f";
            3'd3:    r = "i";
            3'd4:    r = "n";
            3'd5:    r = "i";
            3'd6:    r = "t";
            default: r = "y";
        endcase
        return r;
    endfunction

endpackage

/* src/radix_integer_string_parser.sv */
// Top level of the radix integer string parser: input register, parse step, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_ch, i_radix, i_last, i_empty_req
//  out     | source    | o_out_valid / i_out_stall | o_status, o_value, o_negative, o_overflow
//
// One character word per cycle sustained while no word that ends a string
// waits on a stalled result; a word is held in the input register from its
// accepting edge, and a result it ends goes through the parse step into the
// result register. The parse step is one multiply-add of the accumulator by
// the radix plus prefix and word-match logic; the parse state is its only loop.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parse state to start of string.
// A stalled result only holds back words that end a string; other
// characters keep flowing into the parse state until such a word is held.
module radix_integer_string_parser #(
    parameter int VALUE_WIDTH = risp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [risp_pkg::CH_W-1:0]     i_ch,
    input  logic [risp_pkg::RADIX_W-1:0]  i_radix,
    input  logic                          i_last,
    input  logic                          i_empty_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_negative,
    output logic                          o_overflow
);

    risp_pkg::t_item        in_item;
    risp_pkg::t_item        held_item;
    logic                   held_valid;
    logic                   advance;
    logic                   out_free;
    logic                   res_valid;
    risp_pkg::t_flags       res_flags;
    logic [VALUE_WIDTH-1:0] res_value;
    risp_pkg::t_flags       out_flags;
    logic [VALUE_WIDTH-1:0] out_value;

    assign in_item.ch        = i_ch;
    assign in_item.radix     = i_radix;
    assign in_item.last      = i_last;
    assign in_item.empty_req = i_empty_req;

    // Input register: frees as soon as its word moves into the parse state
    risp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Parse step: a word ending a string needs room in the result register
    risp_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_out_free   (out_free),
        .o_advance    (advance),
        .o_res_valid  (res_valid),
        .o_res_flags  (res_flags),
        .o_res_value  (res_value)
    );

    // Result register
    risp_out_reg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_flags (res_flags),
        .i_value (res_value),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_flags (out_flags),
        .o_value (out_value)
    );

    assign o_status   = out_flags.status;
    assign o_value    = out_value;
    assign o_negative = out_flags.negative;
    assign o_overflow = out_flags.overflow;

    // Saturation is only reported on numeric results
    a_ovf_numeric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_status == risp_pkg::ST_NUMBER)
        else $error("overflow flagged on non-numeric result");

    // NaN and infinity carry a clean payload
    a_special_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != risp_pkg::ST_NUMBER
        |-> o_value == '0 && !o_negative && !o_overflow)
        else $error("special result with nonzero payload");

    // An unsigned result never shows a negative value
    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_negative |-> !o_value[VALUE_WIDTH-1])
        else $error("positive result with sign bit set");

    // Input backpressure only comes from a held, stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

/* src/risp_in_reg.sv */
// Input register with stall toward the upstream side.
module risp_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  risp_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_stall,
    output logic            o_valid,
    output risp_pkg::t_item o_item
);

    logic            r_valid;
    risp_pkg::t_item r_item;
    logic            accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/risp_core.sv */
// Per-character parse step: prefix handling, word match and radix multiply-add.
module risp_core #(
    parameter int VALUE_WIDTH = risp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    input  risp_pkg::t_item        i_item,
    input  logic                   i_out_free,
    output logic                   o_advance,
    output logic                   o_res_valid,
    output risp_pkg::t_flags       o_res_flags,
    output logic [VALUE_WIDTH-1:0] o_res_value
);

    localparam int AW = VALUE_WIDTH - 1;
    localparam int PW = AW + risp_pkg::RADIX_W + 1;

    risp_pkg::t_phase                  r_phase, n_phase;
    logic                              r_sign, n_sign;
    logic [risp_pkg::RADIX_W-1:0]      r_radix, n_radix;
    logic [AW-1:0]                     r_acc, n_acc;
    logic                              r_seen, n_seen;
    logic                              r_stopped, n_stopped;
    logic                              r_forced, n_forced;
    logic                              r_ovf, n_ovf;
    logic [risp_pkg::WIDX_W-1:0]       r_widx, n_widx;
    logic                              r_wmatch, n_wmatch;

    logic                              produce;
    logic                              first_body;
    logic                              take_en;
    logic                              is_x;
    risp_pkg::t_digit                  dg;
    logic [PW-1:0]                     prod_sum;
    logic [VALUE_WIDTH-1:0]            mag;

    assign produce     = i_item.last || i_item.empty_req;
    assign o_advance   = i_item_valid && (!produce || i_out_free);
    assign o_res_valid = i_item_valid && produce && i_out_free;
    assign is_x        = (i_item.ch == risp_pkg::CH_LX) || (i_item.ch == risp_pkg::CH_UX);
    assign dg          = risp_pkg::digit_of(i_item.ch);

    // "Infinity" tracking, C string compare semantics
    always_comb begin
        n_widx   = r_widx;
        n_wmatch = r_wmatch;
        if (r_wmatch && r_widx < risp_pkg::WIDX_LOCK) begin
            if (r_widx == risp_pkg::WIDX_TERM) begin
                if (i_item.ch == risp_pkg::CH_NUL) begin
                    n_widx = risp_pkg::WIDX_LOCK;
                end else begin
                    n_wmatch = 1'b0;
                end
            end else if (i_item.ch == risp_pkg::inf_char(r_widx[2:0])) begin
                n_widx = r_widx + 1'b1;
            end else begin
                n_wmatch = 1'b0;
            end
        end
    end

    // Prefix / phase logic
    always_comb begin
        n_phase    = r_phase;
        n_sign     = r_sign;
        n_radix    = r_radix;
        n_forced   = r_forced;
        first_body = 1'b0;
        take_en    = 1'b0;
        n_seen     = r_seen;
        unique case (r_phase)
            risp_pkg::PH_START: begin
                n_radix = i_item.radix;
                if (i_item.ch == risp_pkg::CH_PLUS) begin
                    n_phase = risp_pkg::PH_AFTER_SIGN;
                end else if (i_item.ch == risp_pkg::CH_MINUS) begin
                    n_sign  = 1'b1;
                    n_phase = risp_pkg::PH_AFTER_SIGN;
                end else begin
                    first_body = 1'b1;
                end
            end
            risp_pkg::PH_AFTER_SIGN: begin
                first_body = 1'b1;
            end
            risp_pkg::PH_AFTER_ZERO: begin
                n_phase = risp_pkg::PH_DIGITS;
                if (is_x && r_radix < risp_pkg::RADIX_XLIMIT) begin
                    if (r_radix != risp_pkg::RADIX_AUTO && r_radix != risp_pkg::RADIX_HEX) begin
                        n_forced = 1'b1;
                    end else begin
                        n_radix = risp_pkg::RADIX_HEX;
                    end
                end else begin
                    // leading zero either picks octal or counts as a digit
                    if (r_radix == risp_pkg::RADIX_AUTO) begin
                        n_radix = risp_pkg::RADIX_OCT;
                    end else begin
                        n_seen = 1'b1;
                    end
                    take_en = 1'b1;
                end
            end
            risp_pkg::PH_DIGITS: begin
                take_en = 1'b1;
            end
        endcase
        if (first_body) begin
            if (i_item.ch == risp_pkg::CH_0 && !i_item.last) begin
                n_phase = risp_pkg::PH_AFTER_ZERO;
            end else begin
                if (n_radix == risp_pkg::RADIX_AUTO) begin
                    n_radix = risp_pkg::RADIX_DEC;
                end
                n_phase = risp_pkg::PH_DIGITS;
                take_en = 1'b1;
            end
        end
    end

    // Digit accumulate; overflow when the sum spills past AW bits
    assign prod_sum = PW'(r_acc) * PW'(n_radix) + PW'(dg.val);

    always_comb begin
        n_acc     = r_acc;
        n_stopped = r_stopped;
        n_ovf     = r_ovf;
        if (take_en && !n_forced && !r_stopped) begin
            if (!dg.ok || dg.val >= n_radix) begin
                n_stopped = 1'b1;
            end else if (!r_ovf) begin
                if (|prod_sum[PW-1:AW]) begin
                    n_acc = {AW{1'b1}};
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod_sum[AW-1:0];
                end
            end
        end
    end

    // Seen flag follows any accepted digit
    logic digit_taken;
    assign digit_taken = take_en && !n_forced && !r_stopped && dg.ok && (dg.val < n_radix);

    // Result formation
    always_comb begin
        mag                  = {1'b0, n_acc};
        o_res_flags.status   = risp_pkg::ST_NUMBER;
        o_res_flags.negative = 1'b0;
        o_res_flags.overflow = 1'b0;
        o_res_value          = '0;
        if (i_item.empty_req) begin
            o_res_flags.status = risp_pkg::ST_NAN;
        end else if (n_forced) begin
            o_res_flags.status = risp_pkg::ST_NUMBER;
        end else if (!(n_seen || digit_taken)) begin
            if (n_wmatch && n_widx >= risp_pkg::WIDX_TERM) begin
                o_res_flags.status = risp_pkg::ST_INF;
            end else begin
                o_res_flags.status = risp_pkg::ST_NAN;
            end
        end else begin
            o_res_value          = n_sign ? -mag : mag;
            o_res_flags.negative = n_sign;
            o_res_flags.overflow = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_advance && produce)) begin
            r_phase   <= risp_pkg::PH_START;
            r_sign    <= 1'b0;
            r_radix   <= '0;
            r_acc     <= '0;
            r_seen    <= 1'b0;
            r_stopped <= 1'b0;
            r_forced  <= 1'b0;
            r_ovf     <= 1'b0;
            r_widx    <= '0;
            r_wmatch  <= 1'b1;
        end else if (o_advance) begin
            r_phase   <= n_phase;
            r_sign    <= n_sign;
            r_radix   <= n_radix;
            r_acc     <= n_acc;
            r_seen    <= n_seen || digit_taken;
            r_stopped <= n_stopped;
            r_forced  <= n_forced;
            r_ovf     <= n_ovf;
            r_widx    <= n_widx;
            r_wmatch  <= n_wmatch;
        end
    end

endmodule

/* src/risp_out_reg.sv */
// Result register holding one word until the downstream side takes it.
module risp_out_reg #(
    parameter int VALUE_WIDTH = risp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  risp_pkg::t_flags       i_flags,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_stall,
    output logic                   o_free,
    output logic                   o_valid,
    output risp_pkg::t_flags       o_flags,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic                   r_valid;
    risp_pkg::t_flags       r_flags;
    logic [VALUE_WIDTH-1:0] r_value;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
            r_value <= i_value;
        end
    end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the radix integer string parser.
module tb;

    // Value width of the instance; the saturation limit follows from it
    localparam int VW = risp_pkg::VALUE_WIDTH_DEF;
    localparam logic [VW-1:0] MAG_LIMIT = {1'b0, {(VW-1){1'b1}}};

    // Text that reads as positive infinity when no digit was taken
    localparam logic [63:0] INF_TEXT = "Infinity";
    // Characters that steer the parser into its less common paths
    localparam logic [87:0] TRICKY_CHARS = {"+-0xX9azAZ", 8'h00};

    localparam int RANDOM_WORDS = 1550;
    localparam int CYCLE_LIMIT  = 300000;
    // Input register plus one parse step, with margin
    localparam int TAIL_CYCLES  = 16;

    // One pending input word plus how the two sides idle while it is out
    typedef struct packed {
        risp_pkg::t_item w;
        logic [6:0]      gap_pct;
        logic [6:0]      stall_pct;
        logic            hold_for_drain;
    } pending_word_t;

    // One parse result as it should leave the block
    typedef struct packed {
        risp_pkg::t_status status;
        logic [VW-1:0]     value;
        logic              negative;
        logic              overflow;
    } parse_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           i_out_stall = 1'b0;
    risp_pkg::t_item                cur_word    = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [1:0]                     o_status;
    logic signed [VW-1:0]           o_value;
    logic                           o_negative;
    logic                           o_overflow;
    logic [risp_pkg::CH_W-1:0]      i_ch;
    logic [risp_pkg::RADIX_W-1:0]   i_radix;
    logic                           i_last;
    logic                           i_empty_req;

    assign i_ch        = cur_word.ch;
    assign i_radix     = cur_word.radix;
    assign i_last      = cur_word.last;
    assign i_empty_req = cur_word.empty_req;

    always #5 i_clk = ~i_clk;

    radix_integer_string_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .i_radix     (i_radix),
        .i_last      (i_last),
        .i_empty_req (i_empty_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_negative  (o_negative),
        .o_overflow  (o_overflow)
    );

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    pending_word_t word_queue[$];     // words still to be offered
    parse_result_t results_due[$];    // predicted results, oldest first
    logic [7:0]    text_buf[$];       // string under construction

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  words_built    = 0;
    int  strings_built  = 0;
    int  words_sent     = 0;
    int  results_seen   = 0;
    int  inf_seen       = 0;
    int  nan_seen       = 0;
    int  sat_seen       = 0;
    int  neg_seen       = 0;
    bit  word_taken     = 1'b0;       // input handshake at the last rising edge
    logic [6:0] rx_stall_pct = '0;

    // Settings that the stimulus generator stamps onto each word
    logic [6:0] gen_gap_pct   = '0;
    logic [6:0] gen_stall_pct = '0;
    logic       gen_drain     = 1'b0;

    // ------------------------------------------------------------------
    // Parser state as the testbench sees it
    // ------------------------------------------------------------------
    risp_pkg::t_phase             ps_phase;
    logic                         ps_neg;
    logic [risp_pkg::RADIX_W-1:0] ps_radix;
    logic [VW-1:0]                ps_mag;
    logic                         ps_seen;       // at least one digit taken
    logic                         ps_stopped;    // a non-digit ended the number
    logic                         ps_pzero;      // leading zero still undecided
    logic                         ps_forced;     // 0x under a radix that forbids it
    logic                         ps_ovf;
    logic [risp_pkg::WIDX_W-1:0]  ps_widx;       // progress through "Infinity"
    logic                         ps_wmatch;

    function automatic void parser_clear();
        ps_phase   = risp_pkg::PH_START;
        ps_neg     = 1'b0;
        ps_radix   = risp_pkg::RADIX_AUTO;
        ps_mag     = '0;
        ps_seen    = 1'b0;
        ps_stopped = 1'b0;
        ps_pzero   = 1'b0;
        ps_forced  = 1'b0;
        ps_ovf     = 1'b0;
        ps_widx    = '0;
        ps_wmatch  = 1'b1;
    endfunction

    function automatic int digit_value(input logic [risp_pkg::CH_W-1:0] c);
        if (c >= risp_pkg::CH_0 && c <= risp_pkg::CH_9) return int'(c - risp_pkg::CH_0);
        if (c >= risp_pkg::CH_LA && c <= risp_pkg::CH_LZ)
            return int'(c - risp_pkg::CH_LA) + 10;
        if (c >= risp_pkg::CH_UA && c <= risp_pkg::CH_UZ)
            return int'(c - risp_pkg::CH_UA) + 10;
        return -1;
    endfunction

    // Multiply-add one digit; saturation is sticky
    function automatic void take_digit_char(input logic [risp_pkg::CH_W-1:0] c);
        int d;
        if (ps_forced || ps_stopped) return;
        d = digit_value(c);
        if (d < 0 || d >= int'(ps_radix)) begin
            ps_stopped = 1'b1;
            return;
        end
        ps_seen = 1'b1;
        if (ps_ovf) return;
        if (ps_mag > (MAG_LIMIT - VW'(d)) / VW'(ps_radix)) begin
            ps_mag = MAG_LIMIT;
            ps_ovf = 1'b1;
        end else begin
            ps_mag = ps_mag * VW'(ps_radix) + VW'(d);
        end
    endfunction

    // First character after an optional sign; a leading zero that is not
    // the last character waits for the next one to decide the radix
    function automatic void first_body(input logic [risp_pkg::CH_W-1:0] c, input logic lst);
        if (c == risp_pkg::CH_0 && !lst) begin
            ps_pzero = 1'b1;
            ps_phase = risp_pkg::PH_AFTER_ZERO;
            return;
        end
        if (ps_radix == risp_pkg::RADIX_AUTO) ps_radix = risp_pkg::RADIX_DEC;
        ps_phase = risp_pkg::PH_DIGITS;
        take_digit_char(c);
    endfunction

    // Advance the parser by one accepted word; returns 1 when a result is due
    function automatic bit predict_word(input risp_pkg::t_item w, output parse_result_t r);
        int idx;
        r = '0;
        if (w.empty_req) begin
            // empty string, or a partial string abandoned
            r.status = risp_pkg::ST_NAN;
            parser_clear();
            return 1'b1;
        end

        // "Infinity" tracking, terminated early by a NUL like a C string
        if (ps_wmatch && ps_widx < risp_pkg::WIDX_LOCK) begin
            if (ps_widx == risp_pkg::WIDX_TERM) begin
                if (w.ch == risp_pkg::CH_NUL) ps_widx = risp_pkg::WIDX_LOCK;
                else ps_wmatch = 1'b0;
            end else begin
                idx = 7 - int'(ps_widx);
                if (w.ch == INF_TEXT[8*idx +: 8]) ps_widx = ps_widx + 1'b1;
                else ps_wmatch = 1'b0;
            end
        end

        case (ps_phase)
            risp_pkg::PH_START: begin
                ps_radix = w.radix;
                if (w.ch == risp_pkg::CH_PLUS) begin
                    ps_phase = risp_pkg::PH_AFTER_SIGN;
                end else if (w.ch == risp_pkg::CH_MINUS) begin
                    ps_neg   = 1'b1;
                    ps_phase = risp_pkg::PH_AFTER_SIGN;
                end else begin
                    first_body(w.ch, w.last);
                end
            end
            risp_pkg::PH_AFTER_SIGN: begin
                first_body(w.ch, w.last);
            end
            risp_pkg::PH_AFTER_ZERO: begin
                ps_pzero = 1'b0;
                ps_phase = risp_pkg::PH_DIGITS;
                if ((w.ch == risp_pkg::CH_LX || w.ch == risp_pkg::CH_UX)
                    && ps_radix < risp_pkg::RADIX_XLIMIT) begin
                    if (ps_radix != risp_pkg::RADIX_AUTO && ps_radix != risp_pkg::RADIX_HEX)
                        ps_forced = 1'b1;
                    else
                        ps_radix = risp_pkg::RADIX_HEX;
                end else begin
                    // automatic radix turns octal and drops the zero
                    if (ps_radix == risp_pkg::RADIX_AUTO) ps_radix = risp_pkg::RADIX_OCT;
                    else take_digit_char(risp_pkg::CH_0);
                    take_digit_char(w.ch);
                end
            end
            default: begin
                take_digit_char(w.ch);
            end
        endcase

        if (!w.last) return 1'b0;

        if (ps_forced) begin
            r.status = risp_pkg::ST_NUMBER;           // sign is dropped on forced zero
        end else if (!ps_seen) begin
            r.status = (ps_wmatch && ps_widx >= risp_pkg::WIDX_TERM) ? risp_pkg::ST_INF
                                                                     : risp_pkg::ST_NAN;
        end else begin
            r.status   = risp_pkg::ST_NUMBER;
            r.value    = ps_neg ? ('0 - ps_mag) : ps_mag;
            r.negative = ps_neg;
            r.overflow = ps_ovf;
        end
        parser_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    task automatic push_word(input logic [7:0] ch, input logic [5:0] radix,
                             input logic last, input logic empty_req);
        pending_word_t p;
        p.w.ch           = ch;
        p.w.radix        = radix;
        p.w.last         = last;
        p.w.empty_req    = empty_req;
        p.gap_pct        = gen_gap_pct;
        p.stall_pct      = gen_stall_pct;
        p.hold_for_drain = gen_drain;
        gen_drain        = 1'b0;
        word_queue.push_back(p);
        words_built++;
    endtask

    task automatic push_literal(input string s, input logic [5:0] radix);
        for (int k = 0; k < s.len(); k++)
            push_word(s[k], radix, k == s.len() - 1, 1'b0);
        strings_built++;
    endtask

    // Empty request with random filler in the ignored fields
    task automatic push_empty();
        push_word(8'($urandom), 6'($urandom), 1'($urandom), 1'b1);
    endtask

    function automatic logic [5:0] pick_radix();
        int r;
        r = $urandom_range(99);
        if (r < 25) return risp_pkg::RADIX_AUTO;
        if (r < 40) return risp_pkg::RADIX_DEC;
        if (r < 55) return risp_pkg::RADIX_HEX;
        if (r < 65) return risp_pkg::RADIX_OCT;
        if (r < 70) return 6'd2;
        if (r < 75) return 6'd36;
        if (r < 78) return 6'd1;
        if (r < 82) return 6'($urandom_range(37, 63));
        return 6'($urandom_range(1, 36));
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return risp_pkg::CH_0 + 8'(v);
        return ($urandom_range(1) ? risp_pkg::CH_LA : risp_pkg::CH_UA) + 8'(v - 10);
    endfunction

    // Well-formed number: sign, prefix, digits, occasional stray characters
    task automatic build_number(input logic [5:0] radix);
        int pfx;
        int lim;
        int n;
        pfx = $urandom_range(9);
        case ($urandom_range(3))
            0:       text_buf.push_back(risp_pkg::CH_PLUS);
            1:       text_buf.push_back(risp_pkg::CH_MINUS);
            default: ;
        endcase
        if (pfx < 2) begin
            text_buf.push_back(risp_pkg::CH_0);
            text_buf.push_back(pfx == 0 ? risp_pkg::CH_LX : risp_pkg::CH_UX);
        end else if (pfx < 4) begin
            text_buf.push_back(risp_pkg::CH_0);
        end
        if (radix == risp_pkg::RADIX_AUTO) lim = (pfx < 2) ? 16 : (pfx < 4) ? 8 : 10;
        else lim = (radix > 6'd36) ? 36 : int'(radix);
        n = $urandom_range(99);
        if (n < 5) n = 0;
        else if (n < 20) n = $urandom_range(12, 30);   // often long enough to saturate
        else n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0) text_buf.push_back(8'($urandom));
            else text_buf.push_back(digit_char($urandom_range(lim - 1)));
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom));
    endtask

    // "Infinity" exact, NUL-terminated, extended, cut short, miscased, signed
    task automatic build_infinity();
        string s;
        int    k;
        s = "Infinity";
        for (int j = 0; j < s.len(); j++) text_buf.push_back(s[j]);
        case ($urandom_range(5))
            0: ;
            1: begin
                text_buf.push_back(risp_pkg::CH_NUL);
                repeat ($urandom_range(3)) text_buf.push_back(8'($urandom));
            end
            2: text_buf.push_back(8'($urandom));
            3: repeat ($urandom_range(1, 7)) void'(text_buf.pop_back());
            4: begin
                k = $urandom_range(7);
                text_buf[k] = text_buf[k] ^ 8'h20;
            end
            default: text_buf.push_front($urandom_range(1) ? risp_pkg::CH_PLUS
                                                            : risp_pkg::CH_MINUS);
        endcase
    endtask

    // Short noise, half of it from characters the parser reacts to
    task automatic build_noise();
        int k;
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1)) begin
                k = $urandom_range(10);
                text_buf.push_back(TRICKY_CHARS[8*k +: 8]);
            end else begin
                text_buf.push_back(8'($urandom));
            end
        end
    endtask

    task automatic build_random_string();
        int          kind;
        logic [5:0]  rdx;
        bit          abandon;
        text_buf.delete();
        kind = $urandom_range(99);
        rdx  = pick_radix();
        if (kind < 4) begin
            push_empty();
            strings_built++;
            return;
        end
        if (kind < 72) build_number(rdx);
        else if (kind < 82) build_infinity();
        else build_noise();
        if (text_buf.size() == 0) text_buf.push_back(risp_pkg::CH_0);
        // now and then a string is dropped by an empty request mid-way
        abandon = ($urandom_range(29) == 0);
        for (int k = 0; k < text_buf.size(); k++) begin
            // radix is only read on the first word; garble it elsewhere
            push_word(text_buf[k],
                      (k == 0 || $urandom_range(3) != 0) ? rdx : 6'($urandom),
                      !abandon && (k == text_buf.size() - 1), 1'b0);
        end
        if (abandon) push_empty();
        strings_built++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next word at the falling edge once the current
    // one was taken, or after an idle cycle
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        pending_word_t nxt;
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (word_queue.size() != 0
                && !(word_queue[0].hold_for_drain && results_due.size() != 0)
                && $urandom_range(99) >= word_queue[0].gap_pct) begin
                nxt = word_queue.pop_front();
                cur_word     <= nxt.w;
                i_in_valid   <= 1'b1;
                rx_stall_pct <= nxt.stall_pct;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks results and feeds accepted words to the predictor
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        parse_result_t due;
        parse_result_t want;
        cycle_count++;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result status %0d value %0d with none due",
                                              o_status, o_value));
                end else begin
                    due = results_due.pop_front();
                    results_seen++;
                    if (o_status !== due.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, due.status));
                    if (o_value !== due.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  o_value, $signed(due.value)));
                    if (o_negative !== due.negative)
                        report_mismatch($sformatf("negative %b, expected %b",
                                                  o_negative, due.negative));
                    if (o_overflow !== due.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  o_overflow, due.overflow));
                    if (due.status == risp_pkg::ST_INF) inf_seen++;
                    if (due.status == risp_pkg::ST_NAN) nan_seen++;
                    if (due.overflow) sat_seen++;
                    if (due.negative) neg_seen++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                word_taken = 1'b1;
                words_sent++;
                if (predict_word(cur_word, want)) results_due.push_back(want);
            end
        end
    end

    // Hard stop in case the handshake hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("no progress within %0d cycles", CYCLE_LIMIT);
        $display("radix_integer_string_parser regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int base;
        parser_clear();

        // Directed strings: field extremes and each corner of the grammar
        push_word(8'hFF, 6'd63, 1'b1, 1'b1);    // empty request, top field values
        strings_built++;
        push_literal("0", risp_pkg::RADIX_AUTO);          // lone zero stays decimal
        push_literal("+", 6'd36);                         // sign only
        push_literal("-0x5", risp_pkg::RADIX_DEC);        // forced zero, sign dropped
        push_literal("0Xf", risp_pkg::RADIX_HEX);         // hex prefix under radix 16
        push_literal("07", risp_pkg::RADIX_AUTO);         // automatic octal
        push_literal("01", 6'd1);                         // radix 1 takes only zero
        push_literal("z", 6'd63);                         // radix above 36
        push_literal("Infinity", risp_pkg::RADIX_AUTO);
        push_word(risp_pkg::CH_0 + 8'd1, risp_pkg::RADIX_DEC, 1'b0, 1'b0); // abandoned
        push_word(risp_pkg::CH_0 + 8'd2, risp_pkg::RADIX_DEC, 1'b0, 1'b0);
        push_empty();
        strings_built++;

        // Random strings in four idling phases; each phase opens by
        // holding the sender until every due result has come back
        base = words_built;
        for (int p = 0; p < 4; p++) begin
            gen_gap_pct   = (p == 1) ? 7'd77 : (p == 3) ? 7'd36 : 7'd0;
            gen_stall_pct = (p == 2) ? 7'd77 : (p == 3) ? 7'd36 : 7'd0;
            gen_drain     = 1'b1;
            while (words_built < base + (p + 1) * RANDOM_WORDS / 4)
                build_random_string();
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Everything offered and every predicted result back
        while (word_queue.size() != 0 || i_in_valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("covered %0d strings in %0d words over %0d cycles",
                 strings_built, words_sent, cycle_count);
        $display("checked %0d results: %0d infinity, %0d not-a-number, %0d saturated, %0d negative",
                 results_seen, inf_seen, nan_seen, sat_seen, neg_seen);
        if (mismatch_count == 0) begin
            $display("radix_integer_string_parser regression: pass");
        end else begin
            $display("radix_integer_string_parser regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/risp_pkg.sv
src/risp_in_reg.sv
src/risp_core.sv
src/risp_out_reg.sv
src/radix_integer_string_parser.sv
sim/tb.sv
